/* hdl/lms7_pkg.sv */
// ============================================================================
// lms7_pkg: shared types, constants and glyph tables
// Command and drive word layouts, action codes and seven-segment glyphs.
// ============================================================================
`default_nettype none

package lms7_pkg;

  // Frame geometry
  localparam int ROW_COUNT    = 5;
  localparam int COLUMN_COUNT = 8;
  localparam int ROW_W        = 8;   // one glyph per row
  localparam int COL_W        = 8;   // one-hot column word
  localparam int DRIVE_W      = 5;   // row lines on the drive word
  localparam int SPLIT_ROW    = 3;   // first row of the second scan half
  localparam int SCAN_ROWS    = (ROW_COUNT < DRIVE_W) ? ROW_COUNT : DRIVE_W;

  localparam logic [2:0]       MINUS_ROW = 3'd3;
  localparam logic [ROW_W-1:0] DOT_BIT   = 8'h01;
  localparam logic [ROW_W-1:0] MINUS_BIT = 8'h02;

  // Action codes
  localparam logic [3:0] ACT_TICK    = 4'd0;
  localparam logic [3:0] ACT_DIGIT   = 4'd1;
  localparam logic [3:0] ACT_DEC     = 4'd2;
  localparam logic [3:0] ACT_HEX     = 4'd3;
  localparam logic [3:0] ACT_NOTE    = 4'd4;
  localparam logic [3:0] ACT_DOT_ON  = 4'd5;
  localparam logic [3:0] ACT_DOT_OFF = 4'd6;
  localparam logic [3:0] ACT_CLEAR   = 4'd7;
  localparam logic [3:0] ACT_MINUS   = 4'd8;

  typedef struct packed {
    logic [3:0] action;
    logic [2:0] first_row;
    logic [2:0] second_row;
    logic [7:0] operand_value;
  } cmd_word_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] row_drive;
    logic [COL_W-1:0]   column_select;
  } drv_word_t;

  // Controller to datapath commands, at most one set per cycle
  typedef struct packed {
    logic scan;
    logic wr_digit;
    logic wr_dec;
    logic wr_hex;
    logic wr_note;
    logic dot_on;
    logic dot_off;
    logic clear_row;
    logic minus;
  } dp_cmd_t;

  function automatic logic [ROW_W-1:0] digit_glyph(input logic [7:0] idx);
    logic [ROW_W-1:0] g;
    case (idx)
      8'd0:    g = 8'hFC;
      8'd1:    g = 8'h60;
      8'd2:    g = 8'hDA;
      8'd3:    g = 8'hF2;
      8'd4:    g = 8'h66;
      8'd5:    g = 8'hB6;
      8'd6:    g = 8'hBE;
      8'd7:    g = 8'hE0;
      8'd8:    g = 8'hFE;
      8'd9:    g = 8'hF6;
      8'd10:   g = 8'hEE;
      8'd11:   g = 8'h3E;
      8'd12:   g = 8'h9C;
      8'd13:   g = 8'h7A;
      8'd14:   g = 8'h9E;
      8'd15:   g = 8'h8E;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  // Note names C..B; sharps carry the dot
  function automatic logic [ROW_W-1:0] note_glyph(input logic [3:0] idx);
    logic [ROW_W-1:0] g;
    case (idx)
      4'd0:    g = 8'h9C;
      4'd1:    g = 8'h7B;
      4'd2:    g = 8'h7A;
      4'd3:    g = 8'h9F;
      4'd4:    g = 8'h9E;
      4'd5:    g = 8'h8E;
      4'd6:    g = 8'hBD;
      4'd7:    g = 8'hBC;
      4'd8:    g = 8'hEF;
      4'd9:    g = 8'hEE;
      4'd10:   g = 8'h3F;
      4'd11:   g = 8'h3E;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

/* hdl/lms7_ctrl.sv */
// ============================================================================
// lms7_ctrl: command decode and drive word handshake control
// Decode accepted command words and track the output register occupancy.
// ============================================================================
`default_nettype none

module lms7_ctrl
  import lms7_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  output logic            cmd_stall,
  input  wire logic [3:0] action,
  output logic            drv_valid,
  input  wire logic       drv_stall,
  output dp_cmd_t         dp_cmd
);

  typedef enum logic {OUT_EMPTY, OUT_FULL} state_t;

  state_t state;
  logic   accept;

  // Stall only while a drive word is held and not taken
  assign cmd_stall = (state == OUT_FULL) && drv_stall;
  assign accept    = cmd_valid && !cmd_stall;
  assign drv_valid = (state == OUT_FULL);

  always_comb begin
    dp_cmd = '0;
    if (accept) begin
      case (action)
        ACT_TICK:    dp_cmd.scan      = 1'b1;
        ACT_DIGIT:   dp_cmd.wr_digit  = 1'b1;
        ACT_DEC:     dp_cmd.wr_dec    = 1'b1;
        ACT_HEX:     dp_cmd.wr_hex    = 1'b1;
        ACT_NOTE:    dp_cmd.wr_note   = 1'b1;
        ACT_DOT_ON:  dp_cmd.dot_on    = 1'b1;
        ACT_DOT_OFF: dp_cmd.dot_off   = 1'b1;
        ACT_CLEAR:   dp_cmd.clear_row = 1'b1;
        ACT_MINUS:   dp_cmd.minus     = 1'b1;
        default:     dp_cmd = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= OUT_EMPTY;
    end else if (dp_cmd.scan) begin
      state <= OUT_FULL;
    end else if (!drv_stall) begin
      state <= OUT_EMPTY;
    end
  end

endmodule

`default_nettype wire

/* hdl/lms7_datapath.sv */
// ============================================================================
// lms7_datapath: frame store, glyph decode and column scanner
// Apply row writes, step the scan and register the drive word.
// ============================================================================
`default_nettype none

module lms7_datapath
  import lms7_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire dp_cmd_t   dp_cmd,
  input  wire cmd_word_t cmd,
  output drv_word_t      drv
);

  logic [ROW_W-1:0] frame [ROW_COUNT];
  logic [COL_W-1:0] scan_column;
  logic             scan_half;

  logic [15:0]      dec_prod;
  logic [15:0]      note_prod;
  logic [4:0]       dec_q;
  logic [4:0]       note_q;
  logic [7:0]       dec_diff;
  logic [7:0]       note_diff;
  logic [7:0]       octave;

  logic             a_en;
  logic             b_en;
  logic [2:0]       a_row;
  logic [2:0]       b_row;
  logic [ROW_W-1:0] a_val;
  logic [ROW_W-1:0] b_val;
  logic [ROW_W-1:0] frame_next [ROW_COUNT];

  logic [DRIVE_W-1:0] lit;
  logic [COL_W-1:0]   scan_column_next;

  // Divide by 10 and 12 through reciprocal multiplies, exact for 8-bit values
  always_comb begin
    dec_prod  = {8'd0, cmd.operand_value} * 16'd205;
    note_prod = {8'd0, cmd.operand_value} * 16'd171;
    dec_q     = dec_prod[15:11];
    note_q    = note_prod[15:11];
    dec_diff  = cmd.operand_value - {dec_q, 3'b000} - {2'b00, dec_q, 1'b0};
    note_diff = cmd.operand_value - {note_q, 3'b000} - {1'b0, note_q, 2'b00};
    // Octave below zero wraps to 255 and shows blank
    octave    = (note_q == 5'd0) ? 8'hFF : ({3'b000, note_q} - 8'd1);
  end

  // Two write ports: port b lands after port a and wins on the same row
  always_comb begin
    a_en  = 1'b0;
    b_en  = 1'b0;
    a_row = cmd.first_row;
    b_row = cmd.first_row;
    a_val = '0;
    b_val = '0;
    if (dp_cmd.wr_digit) begin
      a_en  = 1'b1;
      a_val = digit_glyph(cmd.operand_value);
    end else if (dp_cmd.wr_dec) begin
      a_en  = 1'b1;
      b_en  = 1'b1;
      a_row = cmd.second_row;
      a_val = digit_glyph({4'd0, dec_diff[3:0]});
      b_val = digit_glyph({3'd0, dec_q});
    end else if (dp_cmd.wr_hex) begin
      a_en  = 1'b1;
      b_en  = 1'b1;
      a_row = cmd.second_row;
      a_val = digit_glyph({4'd0, cmd.operand_value[3:0]});
      b_val = digit_glyph({4'd0, cmd.operand_value[7:4]});
    end else if (dp_cmd.wr_note) begin
      a_en  = 1'b1;
      b_en  = 1'b1;
      b_row = cmd.second_row;
      a_val = note_glyph(note_diff[3:0]);
      b_val = digit_glyph(octave);
    end else if (dp_cmd.clear_row) begin
      a_en  = 1'b1;
    end
  end

  // Rows past the store never match, so out-of-range writes drop
  always_comb begin
    for (int i = 0; i < ROW_COUNT; i++) begin
      frame_next[i] = frame[i];
      if (b_en && b_row == 3'(i)) begin
        frame_next[i] = b_val;
      end else if (a_en && a_row == 3'(i)) begin
        frame_next[i] = a_val;
      end else if (dp_cmd.dot_on && cmd.first_row == 3'(i)) begin
        frame_next[i] = frame[i] | DOT_BIT;
      end else if (dp_cmd.dot_off && cmd.first_row == 3'(i)) begin
        frame_next[i] = frame[i] & ~DOT_BIT;
      end else if (dp_cmd.minus && MINUS_ROW == 3'(i)) begin
        frame_next[i] = frame[i] | MINUS_BIT;
      end
    end
  end

  // Scan the current half of the current column
  always_comb begin
    lit = '0;
    for (int i = 0; i < SCAN_ROWS; i++) begin
      if ((scan_half ? (i >= SPLIT_ROW) : (i < SPLIT_ROW)) &&
          ((frame[i] & scan_column) != '0)) begin
        lit[i] = 1'b1;
      end
    end
    if (scan_column == '0 || scan_column[COLUMN_COUNT-1]) begin
      scan_column_next = COL_W'(1);
    end else begin
      scan_column_next = scan_column << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROW_COUNT; i++) begin
        frame[i] <= '0;
      end
      scan_column <= COL_W'(1);
      scan_half   <= 1'b0;
    end else begin
      for (int i = 0; i < ROW_COUNT; i++) begin
        frame[i] <= frame_next[i];
      end
      if (dp_cmd.scan) begin
        scan_half <= ~scan_half;
        if (scan_half) begin
          scan_column <= scan_column_next;
        end
      end
    end
  end

  // Drive word register
  always_ff @(posedge clk) begin
    if (dp_cmd.scan) begin
      drv.row_drive     <= ~lit;
      drv.column_select <= scan_column;
    end
  end

endmodule

`default_nettype wire

/* hdl/led_matrix_scan_7seg_display_unit.sv */
// ============================================================================
// led_matrix_scan_7seg_display_unit: LED frame store with multiplexed scan
// Latency: a tick's drive word is valid the cycle after the tick is accepted.
// Throughput: one word per cycle unless the one-entry drive register stalls.
// Reset: frame blank, scan at column zero in the first half, drive empty.
// ============================================================================
`default_nettype none

module led_matrix_scan_7seg_display_unit
  import lms7_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  // Command channel
  input  wire logic      cmd_valid,
  output logic           cmd_stall,
  input  wire cmd_word_t cmd,
  // Drive channel
  output logic           drv_valid,
  input  wire logic      drv_stall,
  output drv_word_t      drv
);

  // Update commands change only the frame store and give no drive word.
  // A tick reads three rows (first half) or the remaining rows (second
  // half) at the current column and loads the drive register; the column
  // steps after the second half and wraps after the last column.
  // The command side stalls only while an untaken drive word sits in the
  // register, so a new word is taken in the same cycle the old one leaves.

  dp_cmd_t dp_cmd;

  lms7_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .action    (cmd.action),
    .drv_valid (drv_valid),
    .drv_stall (drv_stall),
    .dp_cmd    (dp_cmd)
  );

  lms7_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .dp_cmd (dp_cmd),
    .cmd    (cmd),
    .drv    (drv)
  );

`ifndef SYNTHESIS
  // An accepted tick always leaves a drive word behind
  a_tick_loads: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall && cmd.action == ACT_TICK) |=> drv_valid)
    else $error("accepted tick did not produce a drive word");

  // The command side holds only behind a pending drive word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> drv_valid)
    else $error("command stalled with empty drive register");

  // Exactly one column is driven
  a_col_onehot: assert property (@(posedge clk) disable iff (rst)
    drv_valid |-> $onehot(drv.column_select))
    else $error("column select is not one-hot");
`endif

endmodule

`default_nettype wire

/* test/led_drive_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_drive_checker: predicts and checks the LED scan drive words
// Keeps its own frame store and scan position and updates them from every
// accepted command word. Each accepted drive word is compared with the oldest
// predicted one.
// ----------------------------------------------------------------------------

module led_drive_checker
  import lms7_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  logic      cmd_stall,
  input  cmd_word_t cmd,
  input  logic      drv_valid,
  input  logic      drv_stall,
  input  drv_word_t drv,
  output int        fail_count,
  output int        pending_words,
  output int        words_checked
);

  localparam logic [ROW_W-1:0] BLANK = 8'h00;

  // Segment patterns a..g in bits 7..1, dot in bit 0; entry 0 sits at the LSB
  localparam logic [16*8-1:0] SEG_DIGIT = {
    8'h8E, 8'h9E, 8'h7A, 8'h9C, 8'h3E, 8'hEE, 8'hF6, 8'hFE,
    8'hE0, 8'hBE, 8'hB6, 8'h66, 8'hF2, 8'hDA, 8'h60, 8'hFC
  };
  // Note names C..B, sharps with the dot lit
  localparam logic [12*8-1:0] SEG_NOTE = {
    8'h3E, 8'h3F, 8'hEE, 8'hEF, 8'hBC, 8'hBD,
    8'h8E, 8'h9E, 8'h9F, 8'h7A, 8'h7B, 8'h9C
  };

  logic [ROW_W-1:0] frame [ROW_COUNT];
  logic [COL_W-1:0] scan_col;
  logic             scan_second;
  drv_word_t        drive_due [$];
  drv_word_t        want;
  int               mismatches;
  int               checked;

  function automatic logic [ROW_W-1:0] seg_of_digit(input int unsigned idx);
    return (idx < 16) ? SEG_DIGIT[idx*8 +: 8] : BLANK;
  endfunction

  function automatic void put_row(input logic [2:0] row, input logic [ROW_W-1:0] seg);
    if (row < ROW_COUNT) frame[row] = seg;
  endfunction

  function automatic void apply_command(input cmd_word_t c);
    int unsigned      v;
    logic [7:0]       octave;
    logic [DRIVE_W-1:0] lit;
    int               lo;
    int               hi;
    drv_word_t        w;
    v = c.operand_value;
    case (c.action)
      ACT_TICK: begin
        lit = '0;
        lo  = scan_second ? SPLIT_ROW : 0;
        hi  = scan_second ? DRIVE_W : SPLIT_ROW;
        for (int r = lo; r < hi; r++) begin
          if (r < ROW_COUNT && (frame[r] & scan_col) != '0) lit[r] = 1'b1;
        end
        w.row_drive     = ~lit;
        w.column_select = scan_col;
        drive_due.push_back(w);
        if (scan_second) begin
          if (scan_col == '0 || scan_col[COLUMN_COUNT-1]) scan_col = 1;
          else scan_col = scan_col << 1;
        end
        scan_second = ~scan_second;
      end
      ACT_DIGIT: put_row(c.first_row, seg_of_digit(v));
      ACT_DEC: begin
        put_row(c.second_row, seg_of_digit(v % 10));
        put_row(c.first_row, seg_of_digit(v / 10));
      end
      ACT_HEX: begin
        put_row(c.second_row, seg_of_digit(v % 16));
        put_row(c.first_row, seg_of_digit(v / 16));
      end
      ACT_NOTE: begin
        // octave wraps to 255 below the first octave and shows blank
        octave = 8'(v / 12) - 8'd1;
        put_row(c.first_row, SEG_NOTE[(v % 12)*8 +: 8]);
        put_row(c.second_row, seg_of_digit(octave));
      end
      ACT_DOT_ON: begin
        if (c.first_row < ROW_COUNT) frame[c.first_row] = frame[c.first_row] | DOT_BIT;
      end
      ACT_DOT_OFF: begin
        if (c.first_row < ROW_COUNT) frame[c.first_row] = frame[c.first_row] & ~DOT_BIT;
      end
      ACT_CLEAR: put_row(c.first_row, BLANK);
      ACT_MINUS: begin
        if (ROW_COUNT > MINUS_ROW) frame[MINUS_ROW] = frame[MINUS_ROW] | MINUS_BIT;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROW_COUNT; r++) frame[r] = BLANK;
      scan_col    = 1;
      scan_second = 1'b0;
      drive_due.delete();
      mismatches  = 0;
      checked     = 0;
    end else begin
      // Check the drive word before the command of this edge: it comes from older ticks
      if (drv_valid && !drv_stall) begin
        checked++;
        if (drive_due.size() == 0) begin
          $error("drive word %h arrived with nothing expected", drv);
          mismatches++;
        end else begin
          want = drive_due.pop_front();
          if (drv.row_drive !== want.row_drive) begin
            $error("row_drive: expected %h, actual %h", want.row_drive, drv.row_drive);
            mismatches++;
          end
          if (drv.column_select !== want.column_select) begin
            $error("column_select: expected %h, actual %h",
                   want.column_select, drv.column_select);
            mismatches++;
          end
        end
      end
      if (cmd_valid && !cmd_stall) apply_command(cmd);
    end
    pending_words <= drive_due.size();
    fail_count    <= mismatches;
    words_checked <= checked;
  end

endmodule

/* test/tb_led_matrix_scan_7seg_display_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_matrix_scan_7seg_display_unit: command stream and verdict
// Drives directed and then random command words into the LED scan unit with
// random gaps and random drive stalls, and leaves all checking to the
// drive word checker instantiated beside the unit.
// ----------------------------------------------------------------------------

module tb_led_matrix_scan_7seg_display_unit;
  import lms7_pkg::*;

  localparam int ITEM_TOTAL = 1800;
  localparam int PHASE_LEN  = 150;   // items between changes of flow style
  localparam int MAX_WAIT   = 8;     // longest gap or stall, in cycles
  localparam int TAIL_WAIT  = 8;     // cycles after the last drive word

  // Codes the unit does not decode
  localparam logic [3:0] ACT_UNUSED_LO = ACT_MINUS + 4'd1;
  localparam logic [3:0] ACT_UNUSED_HI = 4'hF;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  cmd_word_t cmd       = '0;
  logic      drv_valid;
  logic      drv_stall = 1'b0;
  drv_word_t drv;

  int  fail_total;
  int  pending;
  int  checked;
  int  sent_words  = 0;
  int  sent_ticks  = 0;
  int  take_wait   = 0;
  bit  quick_send  = 1'b0;
  bit  quick_take  = 1'b0;

  always #5 clk = ~clk;

  led_matrix_scan_7seg_display_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .drv_valid (drv_valid),
    .drv_stall (drv_stall),
    .drv       (drv)
  );

  led_drive_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .cmd           (cmd),
    .drv_valid     (drv_valid),
    .drv_stall     (drv_stall),
    .drv           (drv),
    .fail_count    (fail_total),
    .pending_words (pending),
    .words_checked (checked)
  );

  // Drive side: after each accepted drive word, stall for a drawn number of
  // cycles; in quick phases take every word at once.
  always @(posedge clk) begin
    if (rst) begin
      drv_stall <= 1'b0;
      take_wait = 0;
    end else if (drv_valid && !drv_stall) begin
      take_wait = quick_take ? 0 : $urandom_range(0, MAX_WAIT);
      drv_stall <= (take_wait != 0);
    end else if (take_wait != 0) begin
      take_wait--;
      drv_stall <= (take_wait != 0);
    end
  end

  function automatic cmd_word_t make_word(input logic [3:0] act, input logic [2:0] r1,
                                          input logic [2:0] r2, input logic [7:0] v);
    cmd_word_t w;
    w.action        = act;
    w.first_row     = r1;
    w.second_row    = r2;
    w.operand_value = v;
    return w;
  endfunction

  // Mostly rows that exist, and values over the whole field range with
  // values near the glyph limits mixed in
  function automatic cmd_word_t random_word();
    cmd_word_t w;
    int        pick;
    w.first_row  = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, ROW_COUNT-1))
                                               : 3'($urandom_range(0, 7));
    w.second_row = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, ROW_COUNT-1))
                                               : 3'($urandom_range(0, 7));
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0:       w.operand_value = 8'h00;
        1:       w.operand_value = 8'hFF;
        2:       w.operand_value = 8'($urandom_range(9, 17));
        default: w.operand_value = 8'($urandom_range(0, 15));
      endcase
    end else begin
      w.operand_value = 8'($urandom);
    end
    pick = $urandom_range(0, 99);
    if      (pick < 45) w.action = ACT_TICK;
    else if (pick < 53) w.action = ACT_DIGIT;
    else if (pick < 61) w.action = ACT_DEC;
    else if (pick < 69) w.action = ACT_HEX;
    else if (pick < 77) w.action = ACT_NOTE;
    else if (pick < 82) w.action = ACT_DOT_ON;
    else if (pick < 87) w.action = ACT_DOT_OFF;
    else if (pick < 92) w.action = ACT_CLEAR;
    else if (pick < 95) w.action = ACT_MINUS;
    else                w.action = 4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    return w;
  endfunction

  // Present one command word after a drawn gap and hold it until accepted.
  // Called at a rising edge, returns at the edge that took the word.
  task automatic send_word(input cmd_word_t w);
    int gap;
    gap = quick_send ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= w;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sent_words++;
    if (w.action == ACT_TICK) sent_ticks++;
  endtask

  // Drop valid and hold off until every predicted drive word has come back
  task automatic drain_expected();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: blank frame scan, every action, field extremes and the
    // corner cases of glyph lookup and row addressing
    send_word(make_word(ACT_TICK,      3'd0, 3'd0, 8'h00));
    send_word(make_word(ACT_TICK,      3'd7, 3'd7, 8'hFF));
    send_word(make_word(ACT_DIGIT,     3'd0, 3'd0, 8'd0));
    send_word(make_word(ACT_DIGIT,     3'd4, 3'd0, 8'd15));
    send_word(make_word(ACT_DIGIT,     3'd2, 3'd0, 8'd16));   // past the table: blank
    send_word(make_word(ACT_DIGIT,     3'd7, 3'd7, 8'd255));  // no such row: ignored
    send_word(make_word(ACT_DEC,       3'd0, 3'd1, 8'd99));
    send_word(make_word(ACT_DEC,       3'd2, 3'd3, 8'd255));  // tens of 25 show blank
    send_word(make_word(ACT_DEC,       3'd4, 3'd4, 8'd42));   // same row: tens win
    send_word(make_word(ACT_HEX,       3'd0, 3'd1, 8'hA5));
    send_word(make_word(ACT_HEX,       3'd3, 3'd3, 8'hF0));   // same row: high nibble wins
    send_word(make_word(ACT_NOTE,      3'd0, 3'd1, 8'd0));    // octave underflow: blank
    send_word(make_word(ACT_NOTE,      3'd2, 3'd3, 8'd255));  // octave past the table
    send_word(make_word(ACT_NOTE,      3'd4, 3'd4, 8'd25));   // same row: octave wins
    send_word(make_word(ACT_NOTE,      3'd1, 3'd2, 8'd13));   // sharp with the dot
    send_word(make_word(ACT_DOT_ON,    3'd0, 3'd0, 8'd0));
    send_word(make_word(ACT_DOT_ON,    3'd6, 3'd0, 8'd0));
    send_word(make_word(ACT_DOT_OFF,   3'd0, 3'd0, 8'd0));
    send_word(make_word(ACT_CLEAR,     3'd1, 3'd0, 8'd0));
    send_word(make_word(ACT_CLEAR,     3'd5, 3'd0, 8'd0));
    send_word(make_word(ACT_MINUS,     3'd0, 3'd0, 8'd0));
    send_word(make_word(ACT_UNUSED_LO, 3'd2, 3'd3, 8'd7));
    send_word(make_word(ACT_UNUSED_HI, 3'd7, 3'd7, 8'hFF));
    send_word(make_word(ACT_TICK,      3'd0, 3'd0, 8'h00));
    send_word(make_word(ACT_TICK,      3'd0, 3'd0, 8'h00));
    drain_expected();

    // Random: change flow style every phase, and hold off for a full drain
    // every second phase so the unit runs empty between bursts
    for (int n = 0; n < ITEM_TOTAL; n++) begin
      if (n % PHASE_LEN == 0) begin
        if (n != 0 && n % (2*PHASE_LEN) == 0) drain_expected();
        quick_send = ($urandom_range(0, 3) == 0);
        quick_take <= ($urandom_range(0, 3) == 0);
      end
      send_word(random_word());
    end

    // Wind down: wait out the outstanding drive words and the unit's latency
    drain_expected();
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Sent %0d command words, %0d of them scan ticks; checked %0d drive words.",
             sent_words, sent_ticks, checked);
    if (fail_total == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5_000_000;
    $display("Timed out with %0d drive words outstanding.", pending);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
hdl/lms7_pkg.sv
hdl/lms7_ctrl.sv
hdl/lms7_datapath.sv
hdl/led_matrix_scan_7seg_display_unit.sv
test/led_drive_checker.sv
test/tb_led_matrix_scan_7seg_display_unit.sv
